FILE: rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and constants for the ARP cache scan chain.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned IpW   = 32;
  localparam int unsigned MacW  = 48;
  localparam int unsigned TimeW = 32;
  localparam int unsigned FuncW = 2;
  localparam int unsigned OutIdxW = 4;
  // Entry numbers are carried at the width of the largest supported table.
  localparam int unsigned SlotW = 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  // Running result of the scan, handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              have_free;
    logic [SlotW-1:0]  free_at;
    logic              have_old;
    logic [TimeW-1:0]  old_stamp;
    logic [SlotW-1:0]  old_at;
    logic              found;
    logic [SlotW-1:0]  found_at;
    logic [MacW-1:0]   found_mac;
  } scan_t;

  // Entry write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  slot;
    logic [MacW-1:0]   mac;
    logic [IpW-1:0]    ip;
    logic [TimeW-1:0]  stamp;
  } wr_t;

endpackage

FILE: rtl/core/arpc_req_if.sv
// ----------------------------------------------------------------------------
// ARP cache request channel
// Valid/ready channel carrying one cache operation per transfer.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  logic                         valid;
  logic                         ready;
  logic [arpc_pkg::FuncW-1:0]   func;
  logic [arpc_pkg::IpW-1:0]     ip_addr;
  logic [arpc_pkg::MacW-1:0]    mac_addr;
  logic [arpc_pkg::TimeW-1:0]   now_time;

  modport source (output valid, func, ip_addr, mac_addr, now_time, input ready);
  modport sink   (input valid, func, ip_addr, mac_addr, now_time, output ready);
endinterface

FILE: rtl/core/arpc_resp_if.sv
// ----------------------------------------------------------------------------
// ARP cache response channel
// Valid/ready channel carrying one operation result per transfer.
// ----------------------------------------------------------------------------
interface arpc_resp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [arpc_pkg::OutIdxW-1:0]   entry_index;
  logic [arpc_pkg::MacW-1:0]      mac_out;

  modport source (output valid, hit, entry_index, mac_out, input ready);
  modport sink   (input valid, hit, entry_index, mac_out, output ready);
endinterface

FILE: rtl/core/arpc_cell.sv
// ----------------------------------------------------------------------------
// ARP cache cell
// Holds one table entry and folds it into the scan record passing through.
// ----------------------------------------------------------------------------
module arpc_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [arpc_pkg::IpW-1:0]    key_i,
  input  arpc_pkg::scan_t             scan_i,
  output arpc_pkg::scan_t             scan_o,
  input  arpc_pkg::wr_t               wr_i
);

  localparam logic [arpc_pkg::SlotW-1:0] MyIdx = arpc_pkg::SlotW'(INDEX);

  logic [arpc_pkg::MacW-1:0]  mac_q;
  logic [arpc_pkg::IpW-1:0]   ip_q;
  logic [arpc_pkg::TimeW-1:0] stamp_q;
  arpc_pkg::scan_t            scan_d, scan_q;
  logic                       occupied;
  logic                       match;

  assign occupied = (mac_q != '0);
  assign match    = occupied && (ip_q == key_i);

  always_comb begin
    scan_d = scan_i;
    if (!scan_i.found && match) begin
      scan_d.found     = 1'b1;
      scan_d.found_at  = MyIdx;
      scan_d.found_mac = mac_q;
    end
    if (!occupied && !scan_i.have_free) begin
      scan_d.have_free = 1'b1;
      scan_d.free_at   = MyIdx;
    end
    if (occupied && (!scan_i.have_old || (stamp_q < scan_i.old_stamp))) begin
      scan_d.have_old  = 1'b1;
      scan_d.old_stamp = stamp_q;
      scan_d.old_at    = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      mac_q   <= '0;
      ip_q    <= '0;
      stamp_q <= '0;
    end else begin
      scan_q <= scan_d;
      if (wr_i.en && (wr_i.slot == MyIdx)) begin
        mac_q   <= wr_i.mac;
        ip_q    <= wr_i.ip;
        stamp_q <= wr_i.stamp;
      end
    end
  end

  assign scan_o = scan_q;

endmodule

FILE: rtl/core/arp_cache_table.sv
// ----------------------------------------------------------------------------
// ARP cache table
// IPv4-to-MAC cache with add, delete and search, oldest-stamp replacement.
//
//   Channel  Direction  Payload
//   req_i    in         func, ip_addr, mac_addr, now_time
//   resp_o   out        hit, entry_index, mac_out
//
// An operation passes from the request registers through the scan register
// of each cell to the scan capture; the result is then decided and written.
// One operation is in flight at a time; the next request is taken the cycle
// after the table write, even while a result waits.
// Reset clears every entry at once, so the table is usable right after it.
// A stalled result holds the finished scan until the output register frees.
// ----------------------------------------------------------------------------
module arp_cache_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  arpc_req_if.sink           req_i,
  arpc_resp_if.source        resp_o
);

  arpc_pkg::scan_t chain [ENTRIES+1];
  arpc_pkg::wr_t   wr;

  logic                          busy_q;
  logic                          start_q;
  logic                          done_q;
  arpc_pkg::scan_t               done_rec_q;
  logic [arpc_pkg::FuncW-1:0]    func_q;
  logic [arpc_pkg::IpW-1:0]      key_q;
  logic [arpc_pkg::MacW-1:0]     mac_q;
  logic [arpc_pkg::TimeW-1:0]    now_q;

  logic                          out_valid_q;
  logic                          hit_q, hit_d;
  logic [arpc_pkg::OutIdxW-1:0]  idx_q, idx_d;
  logic [arpc_pkg::MacW-1:0]     mac_out_q, mac_out_d;
  logic [arpc_pkg::SlotW-1:0]    slot;

  logic accept;
  logic take;

  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign take        = done_q && (!out_valid_q || resp_o.ready);

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start_q;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arpc_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .scan_i (chain[i]),
      .scan_o (chain[i+1]),
      .wr_i   (wr)
    );
  end

  always_comb begin
    wr        = '0;
    hit_d     = 1'b0;
    slot      = '0;
    mac_out_d = '0;
    unique case (func_q)
      arpc_pkg::FUNC_ADD: begin
        hit_d = 1'b1;
        if (done_rec_q.found) begin
          slot = done_rec_q.found_at;
        end else if (done_rec_q.have_free) begin
          slot = done_rec_q.free_at;
        end else begin
          slot = done_rec_q.old_at;
        end
        wr.en    = take;
        wr.slot  = slot;
        wr.mac   = mac_q;
        wr.ip    = key_q;
        wr.stamp = now_q;
      end
      arpc_pkg::FUNC_DELETE: begin
        if (done_rec_q.found) begin
          hit_d   = 1'b1;
          slot    = done_rec_q.found_at;
          wr.en   = take;
          wr.slot = slot;
        end
      end
      arpc_pkg::FUNC_SEARCH: begin
        if (done_rec_q.found) begin
          hit_d     = 1'b1;
          slot      = done_rec_q.found_at;
          mac_out_d = done_rec_q.found_mac;
        end
      end
      default: begin
      end
    endcase
    idx_d = slot[arpc_pkg::OutIdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (chain[ENTRIES].valid) begin
        done_q <= 1'b1;
      end else if (take) begin
        done_q <= 1'b0;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (resp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      key_q  <= req_i.ip_addr;
      mac_q  <= req_i.mac_addr;
      now_q  <= req_i.now_time;
    end
    if (chain[ENTRIES].valid) begin
      done_rec_q <= chain[ENTRIES];
    end
    if (take) begin
      hit_q     <= hit_d;
      idx_q     <= idx_d;
      mac_out_q <= mac_out_d;
    end
  end

  assign resp_o.valid       = out_valid_q;
  assign resp_o.hit         = hit_q;
  assign resp_o.entry_index = idx_q;
  assign resp_o.mac_out     = mac_out_q;

  logic [ENTRIES+1:0] stage_valid;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_vld
    assign stage_valid[i] = chain[i+1].valid;
  end
  assign stage_valid[ENTRIES]   = start_q;
  assign stage_valid[ENTRIES+1] = done_q;

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(stage_valid))
    else $error("More than one operation is in the scan chain.");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (stage_valid == '0))
    else $error("Scan activity while the table is idle.");

  a_result_from_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(done_q))
    else $error("Result raised without a finished scan.");

  a_write_only_on_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> take)
    else $error("Table written outside the completion cycle.");

endmodule
